FILE: sv/pll_pkg.sv
// ----------------------------------------------------------------------------
// pll_pkg: shared definitions for the PIN lock with lockout
// Codes, reset values, the scanner's status struct and the PIN format check.
// ----------------------------------------------------------------------------
package pll_pkg;

  localparam int MAX_USERS_DEFAULT = 8;

  localparam int PIN_W      = 16;
  localparam int PIN_CHARS  = 4;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // Item modes.
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_LOGIN = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Result status codes.
  localparam logic [3:0] STAT_ADDED     = 4'd0;
  localparam logic [3:0] STAT_FULL      = 4'd1;
  localparam logic [3:0] STAT_DUPLICATE = 4'd2;
  localparam logic [3:0] STAT_BAD_FMT   = 4'd3;
  localparam logic [3:0] STAT_OK        = 4'd4;
  localparam logic [3:0] STAT_WRONG     = 4'd5;
  localparam logic [3:0] STAT_WAIT_GO   = 4'd6;
  localparam logic [3:0] STAT_WAITING   = 4'd7;
  localparam logic [3:0] STAT_BLOCKED   = 4'd8;
  localparam logic [3:0] STAT_TICK      = 4'd9;

  // Configuration register indexes (word address).
  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd0;
  localparam logic [1:0] REG_FIRST_WAIT   = 2'd1;
  localparam logic [1:0] REG_SECOND_WAIT  = 2'd2;

  localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd3;
  localparam logic [7:0] FIRST_WAIT_RST   = 8'd30;
  localparam logic [7:0] SECOND_WAIT_RST  = 8'd60;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [3:0] PIN_LEN   = 4'd4;

  typedef enum logic [1:0] {
    PH_NORMAL      = 2'd0,
    PH_FIRST_WAIT  = 2'd1,
    PH_SECOND_WAIT = 2'd2,
    PH_BLOCKED     = 2'd3
  } phase_t;

  typedef struct packed {
    logic             ok;
    logic [PIN_W-1:0] bcd;
  } pin_check_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

  // A PIN is well formed when exactly four characters were typed and each is
  // a decimal digit. The low nibble of an ASCII digit is its BCD value.
  function automatic pin_check_t check_pin(input logic [31:0] bytes,
                                           input logic [3:0]  len);
    pin_check_t r;
    logic [7:0] ch;
    r.ok  = (len == PIN_LEN);
    r.bcd = '0;
    for (int k = 0; k < PIN_CHARS; k++) begin
      ch = bytes[31-8*k -: 8];
      if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
        r.ok = 1'b0;
      end
      r.bcd[PIN_W-1-4*k -: 4] = ch[3:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/pin_lock_with_lockout.sv
// ----------------------------------------------------------------------------
// pin_lock_with_lockout: PIN code lock with attempt lockout
// Stores up to MAX_USERS four-digit PINs, checks logins against them and
// runs a two-stage timed lockout followed by a permanent block.
// ----------------------------------------------------------------------------
// A tick, a rejected item or a malformed PIN is decided in EVAL and gives
// its done strobe from the done register; an add or login that must search
// the stored PINs waits in SCAN until pll_scan reports done.
// The block takes no new item while busy; the search reads one table
// entry per cycle through the single shared comparator in pll_scan.
// Reset (rst, synchronous): empties the table, clears the lockout and loads
// the register defaults. The receiver cannot stall; done lasts one cycle.
// ----------------------------------------------------------------------------
module pin_lock_with_lockout #(
  parameter int MAX_USERS = pll_pkg::MAX_USERS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // Item channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [31:0]                   pin_bytes,
  input  logic [3:0]                    pin_length,
  // Result channel.
  output logic                          done,
  output logic [3:0]                    status,
  output logic [2:0]                    user_index,
  output logic [3:0]                    attempts_left,
  output logic [7:0]                    wait_remaining,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pll_pkg::PADDR_W-1:0]   paddr,
  input  logic [pll_pkg::PDATA_W-1:0]   pwdata,
  output logic [pll_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int UW = $clog2(MAX_USERS + 1);
  localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;

  // The sequencer: EVAL decides whether the table has to be searched, SCAN
  // waits on the search unit, and every item closes with one update, made in its last EVAL or SCAN cycle.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_SCAN = 3'b100
  } seq_state_t;

  seq_state_t state, state_next;

  // Configuration registers.
  logic [3:0] max_attempts;
  logic [7:0] first_wait_seconds;
  logic [7:0] second_wait_seconds;

  // Lock state.
  logic [UW-1:0]          users_stored, users_next;
  logic [3:0]             wrong_count, wrong_next;
  logic                   failed_rounds, failed_next;
  pll_pkg::phase_t        phase, phase_next;
  logic [7:0]             seconds_left, secs_next;

  // The item being worked on.
  logic [1:0]                mode_q;
  logic                      fmt_q;
  logic [pll_pkg::PIN_W-1:0] bcd_q;
  pll_pkg::pin_check_t       chk;

  // Result registers.
  logic [UW-1:0] index_q, index_next;
  logic [3:0]    status_next;
  logic [3:0]    left_next;
  logic [UW+2:0] index_wide;

  // Search unit hookup.
  pll_pkg::scan_rsp_t scan_rsp;
  logic [UW-1:0]      hit_idx;
  logic               scan_go;
  logic               wr_en;

  logic       accept;
  logic       finalize;
  logic       full;
  logic       pin_mode;
  logic       need_scan;
  logic [3:0] eff_max;
  logic [3:0] wrong_inc;
  logic       cfg_wr;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign chk      = pll_pkg::check_pin(pin_bytes, pin_length);

  assign full      = (users_stored >= UW'(MAX_USERS));
  assign pin_mode  = (mode_q == pll_pkg::MODE_ADD) || (mode_q == pll_pkg::MODE_LOGIN);
  // Only a well-formed add or login in the normal phase, with room in the
  // table for an add, needs to look through the stored PINs.
  assign need_scan = pin_mode && (phase == pll_pkg::PH_NORMAL) && fmt_q &&
                     !((mode_q == pll_pkg::MODE_ADD) && full);

  // A zero attempt limit behaves as a limit of one.
  assign eff_max   = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
  assign wrong_inc = wrong_count + 4'd1;

  pll_scan #(
    .MAX_USERS (MAX_USERS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .go      (scan_go),
    .key     (bcd_q),
    .count   (users_stored),
    .wr_en   (wr_en),
    .wr_addr (users_stored[AW-1:0]),
    .wr_data (bcd_q),
    .rsp     (scan_rsp),
    .hit_idx (hit_idx)
  );

  always_comb begin
    state_next  = state;
    scan_go     = 1'b0;
    finalize    = 1'b0;
    wr_en       = 1'b0;
    users_next  = users_stored;
    wrong_next  = wrong_count;
    failed_next = failed_rounds;
    phase_next  = phase;
    secs_next   = seconds_left;
    status_next = pll_pkg::STAT_TICK;
    index_next  = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (need_scan) begin
          scan_go    = 1'b1;
          state_next = S_SCAN;
        end else begin
          finalize   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_rsp.done) begin
          finalize   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finalize) begin
      if (pin_mode) begin
        if (phase == pll_pkg::PH_BLOCKED) begin
          status_next = pll_pkg::STAT_BLOCKED;
        end else if (phase != pll_pkg::PH_NORMAL) begin
          status_next = pll_pkg::STAT_WAITING;
        end else if (mode_q == pll_pkg::MODE_ADD) begin
          // The full check comes ahead of the format check.
          if (full) begin
            status_next = pll_pkg::STAT_FULL;
          end else if (!fmt_q) begin
            status_next = pll_pkg::STAT_BAD_FMT;
          end else if (scan_rsp.hit) begin
            status_next = pll_pkg::STAT_DUPLICATE;
          end else begin
            wr_en       = 1'b1;
            index_next  = users_stored;
            users_next  = users_stored + UW'(1);
            status_next = pll_pkg::STAT_ADDED;
          end
        end else begin
          if (!fmt_q) begin
            // A malformed PIN is not counted as an attempt.
            status_next = pll_pkg::STAT_BAD_FMT;
          end else if (scan_rsp.hit) begin
            index_next  = hit_idx;
            wrong_next  = 4'd0;
            failed_next = 1'b0;
            status_next = pll_pkg::STAT_OK;
          end else if (wrong_inc >= eff_max) begin
            // The round is used up: the first failed round starts the first
            // wait, any later one the second wait.
            wrong_next  = 4'd0;
            status_next = pll_pkg::STAT_WAIT_GO;
            if (!failed_rounds) begin
              failed_next = 1'b1;
              phase_next  = pll_pkg::PH_FIRST_WAIT;
              secs_next   = (first_wait_seconds == 8'd0) ? 8'd1 : first_wait_seconds;
            end else begin
              phase_next  = pll_pkg::PH_SECOND_WAIT;
              secs_next   = (second_wait_seconds == 8'd0) ? 8'd1 : second_wait_seconds;
            end
          end else begin
            wrong_next  = wrong_inc;
            status_next = pll_pkg::STAT_WRONG;
          end
        end
      end else if (mode_q == pll_pkg::MODE_TICK) begin
        // Ticks only count while a wait runs. The end of the first wait
        // frees the lock; the end of the second blocks it for good.
        if (((phase == pll_pkg::PH_FIRST_WAIT) || (phase == pll_pkg::PH_SECOND_WAIT)) &&
            (seconds_left != 8'd0)) begin
          secs_next = seconds_left - 8'd1;
          if (seconds_left == 8'd1) begin
            phase_next = (phase == pll_pkg::PH_FIRST_WAIT) ? pll_pkg::PH_NORMAL
                                                            : pll_pkg::PH_BLOCKED;
          end
        end
      end
    end

    left_next = (wrong_next >= eff_max) ? 4'd0 : (eff_max - wrong_next);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      done                <= 1'b0;
      users_stored        <= '0;
      wrong_count         <= 4'd0;
      failed_rounds       <= 1'b0;
      phase               <= pll_pkg::PH_NORMAL;
      seconds_left        <= 8'd0;
      max_attempts        <= pll_pkg::MAX_ATTEMPTS_RST;
      first_wait_seconds  <= pll_pkg::FIRST_WAIT_RST;
      second_wait_seconds <= pll_pkg::SECOND_WAIT_RST;
    end else begin
      state         <= state_next;
      done          <= finalize;
      users_stored  <= users_next;
      wrong_count   <= wrong_next;
      failed_rounds <= failed_next;
      phase         <= phase_next;
      seconds_left  <= secs_next;
      if (cfg_wr) begin
        case (paddr[3:2])
          pll_pkg::REG_MAX_ATTEMPTS: max_attempts        <= pwdata[3:0];
          pll_pkg::REG_FIRST_WAIT:   first_wait_seconds  <= pwdata[7:0];
          pll_pkg::REG_SECOND_WAIT:  second_wait_seconds <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      fmt_q  <= chk.ok;
      bcd_q  <= chk.bcd;
    end
    if (finalize) begin
      status        <= status_next;
      index_q       <= index_next;
      attempts_left <= left_next;
    end
  end

  // The seconds counter only moves on an update, so it stands as the result.
  assign wait_remaining = seconds_left;

  assign index_wide = {3'b000, index_q};
  assign user_index = index_wide[2:0];

  always_comb begin
    case (paddr[3:2])
      pll_pkg::REG_MAX_ATTEMPTS: prdata = {28'd0, max_attempts};
      pll_pkg::REG_FIRST_WAIT:   prdata = {24'd0, first_wait_seconds};
      pll_pkg::REG_SECOND_WAIT:  prdata = {24'd0, second_wait_seconds};
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: sv/pll_scan.sv
// ----------------------------------------------------------------------------
// pll_scan: PIN table and search unit
// Holds the stored PINs and walks them with one comparator, one entry per
// cycle, until a match is found or every stored entry has been seen.
// ----------------------------------------------------------------------------
module pll_scan #(
  parameter int MAX_USERS = pll_pkg::MAX_USERS_DEFAULT,
  localparam int UW = $clog2(MAX_USERS + 1),
  localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [pll_pkg::PIN_W-1:0] key,
  input  logic [UW-1:0]            count,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [pll_pkg::PIN_W-1:0] wr_data,
  output pll_pkg::scan_rsp_t       rsp,
  output logic [UW-1:0]            hit_idx
);

  logic [pll_pkg::PIN_W-1:0] pin_store [MAX_USERS];
  logic [pll_pkg::PIN_W-1:0] rd_data;
  logic                      active;
  logic                      pend;
  logic [UW-1:0]             issue_idx;
  logic [UW-1:0]             pend_idx;
  logic                      more;
  logic                      hit;

  assign more    = (issue_idx < count);
  assign hit     = active && pend && (rd_data == key);
  assign rsp.hit  = hit;
  assign rsp.done = active && (hit || !more);
  assign hit_idx = pend_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pin_store[wr_addr] <= wr_data;
    end
    rd_data  <= pin_store[issue_idx[AW-1:0]];
    pend_idx <= issue_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pend      <= 1'b0;
      issue_idx <= '0;
    end else if (go) begin
      active    <= 1'b1;
      pend      <= 1'b0;
      issue_idx <= '0;
    end else if (active) begin
      if (rsp.done) begin
        active <= 1'b0;
        pend   <= 1'b0;
      end else begin
        pend <= more;
        if (more) begin
          issue_idx <= issue_idx + UW'(1);
        end
      end
    end
  end

endmodule

FILE: sv/pll_checker.sv
// ----------------------------------------------------------------------------
// pll_checker: port-level checks for the PIN lock
// Watches the item and result ports of the top level over time.
// ----------------------------------------------------------------------------
module pll_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [3:0] status,
  input logic [2:0] user_index
);

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // No result can appear in the cycle right after an item is accepted.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobe too early after acceptance");

  // Each item gives one strobe, and results are never back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  // Only an added or a matched user carries an index.
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != pll_pkg::STAT_ADDED) && (status != pll_pkg::STAT_OK))
      |-> (user_index == 3'd0))
    else $error("user index set on a result that carries none");

endmodule

bind pin_lock_with_lockout pll_checker u_pll_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .user_index (user_index)
);
